### design/kwmh_pkg.sv
// ----------------------------------------------------------------------------
// kwmh_pkg
// Shared types, widths, codes and the key order function for the k-way
// merge source heap.
// ----------------------------------------------------------------------------
package kwmh_pkg;

	// Heap geometry
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = IDX_W + 1;

	// Key and tag widths
	localparam int KEY_BITS = 32;
	localparam int IN_KEY_W = 32;
	localparam int TAG_W    = 8;
	localparam int STATUS_W = 2;

	// Operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [TAG_W-1:0]    tag_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	// One heap entry as held in memory
	typedef struct packed {
		key_t key;
		tag_t tag;
	} entry_t;

	// Strict a > b; signed order flips the sign bit of both operands
	function automatic logic key_greater(key_t a, key_t b, logic sgn);
		key_t sb;
		sb = {sgn, {(KEY_BITS-1){1'b0}}};
		return (a ^ sb) > (b ^ sb);
	endfunction

endpackage

### design/kwmh_if.sv
// ----------------------------------------------------------------------------
// kwmh_if
// Valid/ready channel interfaces for the merge heap: request and result.
// ----------------------------------------------------------------------------

// Request channel: one operation per transaction
interface kwmh_in_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [kwmh_pkg::IN_KEY_W-1:0] key;
	logic [kwmh_pkg::TAG_W-1:0]    source_tag;
	logic                          source_done;

	modport source (output valid, op, key, source_tag, source_done, input ready);
	modport sink   (input valid, op, key, source_tag, source_done, output ready);
endinterface

// Result channel: status and current minimum per transaction
interface kwmh_out_if;
	logic                          valid;
	logic                          ready;
	logic [kwmh_pkg::STATUS_W-1:0] status;
	logic                          min_valid;
	logic [kwmh_pkg::IN_KEY_W-1:0] min_key;
	logic [kwmh_pkg::TAG_W-1:0]    min_source;

	modport source (output valid, status, min_valid, min_key, min_source, input ready);
	modport sink   (input valid, status, min_valid, min_key, min_source, output ready);
endinterface

### design/kway_merge_min_heap_top.sv
// Transactions are handled one at a time; the next is taken once the result is registered.
// Sift runs on one memory with one write port and one registered read port.
// Reset: clears entry count, key order register, sequencer and result valid.
// Heap memory is not cleared; entries are only read below the entry count.
// ----------------------------------------------------------------------------
// kway_merge_min_heap_top
// Binary min-heap of merge sources kept in a synchronous RAM. Push inserts
// and sifts up, pop replaces or removes the top and sifts down, using a
// hole that is filled when the moving entry settles.
// ----------------------------------------------------------------------------
module kway_merge_min_heap_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	kwmh_in_if.sink            in_ch,
	kwmh_out_if.source         out_ch
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_PUT,
		S_LAST,
		S_DN,
		S_DNL,
		S_DNR,
		S_RESP
	} state_t;

	state_t                state_q;
	kwmh_pkg::cnt_t        count_q;
	kwmh_pkg::idx_t        pos_q;
	kwmh_pkg::entry_t      cur_q;
	kwmh_pkg::entry_t      left_q;
	kwmh_pkg::entry_t      top_q;
	kwmh_pkg::status_t     status_q;
	logic                  key_signed_q;
	logic                  out_valid_q;

	// Heap memory, one write and one registered read port
	kwmh_pkg::entry_t      heap_mem [kwmh_pkg::CAPACITY];
	kwmh_pkg::entry_t      rdata_q;
	logic                  mem_we;
	logic                  mem_re;
	kwmh_pkg::idx_t        waddr;
	kwmh_pkg::idx_t        raddr;
	kwmh_pkg::entry_t      wdata;

	logic                  in_acc;
	kwmh_pkg::entry_t      in_entry;
	kwmh_pkg::idx_t        par_idx;
	kwmh_pkg::idx_t        cnt_idx;
	kwmh_pkg::idx_t        last_idx;
	kwmh_pkg::cnt_t        left_c;
	kwmh_pkg::cnt_t        right_c;
	logic                  rd_gt_cur;
	logic                  pick_right;
	kwmh_pkg::entry_t      cmp_e;
	kwmh_pkg::cnt_t        cmp_idx;
	logic                  cur_gt_pick;
	logic                  out_free;

	// Parent of a heap position
	function automatic kwmh_pkg::idx_t parent_of(kwmh_pkg::idx_t p);
		return (p - 1'b1) >> 1;
	endfunction

	assign in_acc   = in_ch.valid & in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_entry = '{key: in_ch.key[kwmh_pkg::KEY_BITS-1:0], tag: in_ch.source_tag};
	assign out_free = !out_valid_q || out_ch.ready;

	// Index arithmetic
	assign cnt_idx  = count_q[kwmh_pkg::IDX_W-1:0];
	assign last_idx = kwmh_pkg::idx_t'(count_q - 1'b1);
	assign par_idx  = parent_of(pos_q);
	assign left_c   = {pos_q, 1'b1};
	assign right_c  = left_c + 1'b1;

	// Key comparisons
	assign rd_gt_cur  = kwmh_pkg::key_greater(rdata_q.key, cur_q.key, key_signed_q);
	assign pick_right = kwmh_pkg::key_greater(left_q.key, rdata_q.key, key_signed_q);
	assign cmp_e      = (state_q == S_DNR && pick_right) ? rdata_q :
	                    ((state_q == S_DNR) ? left_q : rdata_q);
	assign cmp_idx    = (state_q == S_DNR && pick_right) ? right_c : left_c;
	assign cur_gt_pick = kwmh_pkg::key_greater(cur_q.key, cmp_e.key, key_signed_q);

	// Memory access selection
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		waddr  = pos_q;
		raddr  = pos_q;
		wdata  = cur_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && in_ch.op == kwmh_pkg::OP_PUSH &&
				    count_q < kwmh_pkg::CAPACITY) begin
					if (count_q == '0) begin
						mem_we = 1'b1;
						waddr  = '0;
						wdata  = in_entry;
					end else begin
						mem_re = 1'b1;
						raddr  = parent_of(cnt_idx);
					end
				end else if (in_acc && in_ch.op == kwmh_pkg::OP_POP &&
				             in_ch.source_done && count_q > 1) begin
					mem_re = 1'b1;
					raddr  = last_idx;
				end
			end
			S_UP: begin
				mem_we = 1'b1;
				if (rd_gt_cur) begin
					wdata = rdata_q;
					if (par_idx != '0) begin
						mem_re = 1'b1;
						raddr  = parent_of(par_idx);
					end
				end
			end
			S_PUT: begin
				mem_we = 1'b1;
			end
			S_DN: begin
				if (left_c >= count_q) begin
					mem_we = 1'b1;
				end else begin
					mem_re = 1'b1;
					raddr  = left_c[kwmh_pkg::IDX_W-1:0];
				end
			end
			S_DNL: begin
				if (right_c < count_q) begin
					mem_re = 1'b1;
					raddr  = right_c[kwmh_pkg::IDX_W-1:0];
				end else begin
					mem_we = 1'b1;
					wdata  = cur_gt_pick ? cmp_e : cur_q;
				end
			end
			S_DNR: begin
				mem_we = 1'b1;
				wdata  = cur_gt_pick ? cmp_e : cur_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Heap memory and mirrored root entry
	always_ff @(posedge clk) begin
		if (mem_we) begin
			heap_mem[waddr] <= wdata;
			if (waddr == '0) begin
				top_q <= wdata;
			end
		end
		if (mem_re) begin
			rdata_q <= heap_mem[raddr];
		end
	end

	// Key order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_signed_q <= 1'b0;
		end else if (cfg_we) begin
			key_signed_q <= cfg_wdata;
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			count_q          <= '0;
			out_valid_q      <= 1'b0;
			pos_q            <= '0;
			status_q         <= kwmh_pkg::ST_OK;
			cur_q            <= '0;
			left_q           <= '0;
			out_ch.status    <= '0;
			out_ch.min_valid <= 1'b0;
			out_ch.min_key   <= '0;
			out_ch.min_source <= '0;
		end else begin
			// result taken; a new one is loaded below only in S_RESP
			if (out_ch.ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_ch.op == kwmh_pkg::OP_PUSH) begin
							if (count_q >= kwmh_pkg::CAPACITY) begin
								status_q <= kwmh_pkg::ST_FULL;
								state_q  <= S_RESP;
							end else begin
								status_q <= kwmh_pkg::ST_OK;
								cur_q    <= in_entry;
								pos_q    <= cnt_idx;
								count_q  <= count_q + 1'b1;
								state_q  <= (count_q == '0) ? S_RESP : S_UP;
							end
						end else if (count_q == '0) begin
							status_q <= kwmh_pkg::ST_EMPTY;
							state_q  <= S_RESP;
						end else if (in_ch.source_done) begin
							count_q <= count_q - 1'b1;
							if (count_q == 1) begin
								status_q <= kwmh_pkg::ST_EMPTY;
								state_q  <= S_RESP;
							end else begin
								status_q <= kwmh_pkg::ST_OK;
								state_q  <= S_LAST;
							end
						end else begin
							status_q <= kwmh_pkg::ST_OK;
							cur_q    <= '{key: in_entry.key, tag: top_q.tag};
							pos_q    <= '0;
							state_q  <= S_DN;
						end
					end
				end
				S_UP: begin
					if (rd_gt_cur) begin
						pos_q   <= par_idx;
						state_q <= (par_idx == '0) ? S_PUT : S_UP;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_PUT: begin
					state_q <= S_RESP;
				end
				S_LAST: begin
					cur_q   <= rdata_q;
					pos_q   <= '0;
					state_q <= S_DN;
				end
				S_DN: begin
					state_q <= (left_c >= count_q) ? S_RESP : S_DNL;
				end
				S_DNL: begin
					left_q <= rdata_q;
					if (right_c < count_q) begin
						state_q <= S_DNR;
					end else if (cur_gt_pick) begin
						pos_q   <= cmp_idx[kwmh_pkg::IDX_W-1:0];
						state_q <= S_DN;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_DNR: begin
					if (cur_gt_pick) begin
						pos_q   <= cmp_idx[kwmh_pkg::IDX_W-1:0];
						state_q <= S_DN;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_ch.status    <= status_q;
						out_ch.min_valid <= (count_q != '0);
						out_ch.min_key   <= (count_q != '0) ?
						                    kwmh_pkg::IN_KEY_W'(top_q.key) : '0;
						out_ch.min_source <= (count_q != '0) ? top_q.tag : '0;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;

	// Entry count never passes the heap size
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= kwmh_pkg::CAPACITY)
		else $error("entry count above capacity");

	// Read and write never hit the same entry in one cycle
	a_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (waddr != raddr))
		else $error("memory read and write to the same entry");

	// Pop on an empty heap goes straight to the result with empty status
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_ch.op == kwmh_pkg::OP_POP && count_q == '0) |=>
		(state_q == S_RESP && status_q == kwmh_pkg::ST_EMPTY && count_q == '0))
		else $error("pop on empty heap mishandled");

endmodule
